// File: hw/rtl/wildcard_glob_matcher_core_defines.svh
// assertion macros shared by the glob matcher checkers
// no dependencies; pulled in by the checker file only
`ifndef WILDCARD_GLOB_MATCHER_CORE_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_CORE_DEFINES_SVH

// same-cycle implication under an active-low reset
`define WGM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glob matcher check failed");

// next-cycle implication under an active-low reset
`define WGM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glob matcher check failed");

`endif

// File: hw/rtl/wgm_pkg.sv
// shared types and constants of the glob matcher
// no dependencies; used by the cell, the top level and the checker
package wgm_pkg;

  localparam int MaxPatternDef = 32;

  localparam logic [7:0] StarCode     = 8'h2A;
  localparam logic [7:0] QuestionCode = 8'h3F;

  typedef enum logic {
    REQ_PATTERN = 1'b0,
    REQ_TEXT    = 1'b1
  } req_type_e;

  // kind of wavefront travelling down the cell row
  typedef enum logic {
    OP_BASE = 1'b0,
    OP_TEXT = 1'b1
  } wave_op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_WAIT = 3'b100
  } state_e;

  // message handed from one cell to the next
  typedef struct packed {
    logic       go;
    wave_op_e   op;
    logic [7:0] ch;
    logic       last;
    logic       carry_new;  // new bit of the left neighbor
    logic       carry_old;  // old bit of the left neighbor
    logic       res;        // bit picked up at the pattern end cell
  } wave_t;

endpackage

// File: hw/rtl/wgm_cell.sv
// one pattern position: stored byte, base bit and match bit
// depends on wgm_pkg
module wgm_cell #(
  parameter int MaxPattern = wgm_pkg::MaxPatternDef,
  parameter int Index      = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [$clog2(MaxPattern+1)-1:0]    len_i,
  input  logic                               load_i,
  input  logic [7:0]                         load_char_i,
  input  wgm_pkg::wave_t                     wave_i,
  output wgm_pkg::wave_t                     wave_o
);
  import wgm_pkg::*;

  localparam int LenW = $clog2(MaxPattern + 1);

  logic [7:0] pat_q;
  logic       base_q;
  logic       match_q;
  wave_t      wave_q, wave_d;

  logic in_range, at_end, is_star, is_any, base_bit, text_bit, new_bit;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pat_q <= load_char_i;
    end
  end

  always_comb begin
    in_range = (LenW'(Index) <= len_i);
    at_end   = (LenW'(Index) == len_i);
    is_star  = (pat_q == StarCode);
    is_any   = (pat_q == QuestionCode) || (pat_q == wave_i.ch);
    base_bit = wave_i.carry_new && is_star && in_range;
    if (is_star) begin
      text_bit = wave_i.carry_new | match_q;
    end else if (is_any) begin
      text_bit = wave_i.carry_old;
    end else begin
      text_bit = 1'b0;
    end
    new_bit          = (wave_i.op == OP_BASE) ? base_bit : text_bit;
    wave_d           = wave_i;
    wave_d.carry_new = new_bit;
    wave_d.carry_old = match_q;
    if (at_end) begin
      wave_d.res = new_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= 1'b0;
      match_q <= 1'b0;
      wave_q  <= '0;
    end else begin
      wave_q <= wave_d;
      if (wave_i.go) begin
        if (wave_i.op == OP_BASE) begin
          base_q  <= base_bit;
          match_q <= base_bit;
        end else begin
          // end of a text puts the base row back
          match_q <= wave_i.last ? base_q : text_bit;
        end
      end
    end
  end

  assign wave_o = wave_q;

endmodule

// File: hw/rtl/wildcard_glob_matcher_core.sv
// top level of the glob matcher: input control, cell row, result register
// depends on wgm_pkg and wgm_cell
//
// Glob matcher with '?' for any one byte and '*' for any run of bytes. Pattern
// words (tuser 0) are stored one per cell; the word with tlast closes the
// pattern and yields one result, the empty-text match, with tlast low. Each text
// word (tuser 1) yields one result: bit 0 of tdata says whether the text so far
// matches the whole pattern, tlast marks the word that closes the text, after
// which the row returns to its base state. Bit 1 of tdata reports that the
// pattern ran past MaxPattern bytes; extra bytes are dropped. Text words that
// arrive while a pattern is still open are dropped with no result. A non-last
// pattern word is stored and leaves the input ready. A closing pattern word or
// a text word launches a wavefront that walks the row of MaxPattern cells one
// cell per cycle; the block takes its next word once the wavefront leaves the
// last cell and the output register is free. A finished result waits in the
// output register while the next word is already accepted.
module wildcard_glob_matcher_core #(
  parameter int MaxPattern = wgm_pkg::MaxPatternDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic       s_axis_tlast,   // last
  input  logic       s_axis_tuser,   // [0] req_type
  // result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] matched, [1] overflow, [7:2] zero
  output logic       m_axis_tlast    // text_end
);
  import wgm_pkg::*;

  localparam int LenW = $clog2(MaxPattern + 1);

  state_e           state_q, state_d;
  logic [LenW-1:0]  len_q, len_d, eff_len;
  logic             closed_q, closed_d;
  logic             ovf_q, ovf_d;
  logic             match0_q, match0_d;   // row bit zero, held here
  wave_t            inj_q, inj_d;
  logic             pend_match_q, pend_end_q;
  logic             out_valid_q, out_match_q, out_end_q, out_ovf_q;

  logic                  accept, pat_acc, txt_acc, out_free;
  logic [MaxPattern-1:0] load;
  wave_t                 wave [MaxPattern+1];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pat_acc       = accept && (s_axis_tuser == REQ_PATTERN);
  assign txt_acc       = accept && (s_axis_tuser == REQ_TEXT);
  assign out_free      = !out_valid_q || m_axis_tready;

  // a pattern word after a closed pattern starts over at position zero
  assign eff_len = closed_q ? '0 : len_q;

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    closed_d = closed_q;
    ovf_d    = ovf_q;
    match0_d = match0_q;
    inj_d    = inj_q;
    inj_d.go = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (pat_acc) begin
          if (eff_len == LenW'(MaxPattern)) begin
            len_d = eff_len;
            ovf_d = 1'b1;
          end else begin
            len_d = eff_len + LenW'(1);
            ovf_d = closed_q ? 1'b0 : ovf_q;
          end
          closed_d = s_axis_tlast;
          if (s_axis_tlast) begin
            // build the base row: bit j set while the prefix is all stars
            inj_d.go        = 1'b1;
            inj_d.op        = OP_BASE;
            inj_d.ch        = s_axis_tdata;
            inj_d.last      = 1'b0;
            inj_d.carry_new = 1'b1;
            inj_d.carry_old = 1'b0;
            inj_d.res       = 1'b0;
            match0_d        = 1'b1;
            state_d         = ST_RUN;
          end
        end else if (txt_acc && closed_q) begin
          inj_d.go        = 1'b1;
          inj_d.op        = OP_TEXT;
          inj_d.ch        = s_axis_tdata;
          inj_d.last      = s_axis_tlast;
          inj_d.carry_new = 1'b0;       // new row bit zero is always clear
          inj_d.carry_old = match0_q;
          inj_d.res       = 1'b0;       // empty pattern never matches a text
          match0_d        = s_axis_tlast;
          state_d         = ST_RUN;
        end
      end
      ST_RUN: begin
        if (wave[MaxPattern].go) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      closed_q    <= 1'b1;
      ovf_q       <= 1'b0;
      match0_q    <= 1'b1;
      inj_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      closed_q <= closed_d;
      ovf_q    <= ovf_d;
      match0_q <= match0_d;
      inj_q    <= inj_d;
      if (state_q == ST_WAIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN && wave[MaxPattern].go) begin
      pend_match_q <= wave[MaxPattern].res;
      pend_end_q   <= (wave[MaxPattern].op == OP_TEXT) && wave[MaxPattern].last;
    end
    if (state_q == ST_WAIT && out_free) begin
      out_match_q <= pend_match_q;
      out_end_q   <= pend_end_q;
      out_ovf_q   <= ovf_q;
    end
  end

  assign wave[0] = inj_q;

  // row of cells, position g+1 of the pattern in cell g
  for (genvar g = 0; g < MaxPattern; g++) begin : gen_cell
    assign load[g] = pat_acc && (eff_len == LenW'(g));
    wgm_cell #(
      .MaxPattern (MaxPattern),
      .Index      (g + 1)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .len_i       (len_q),
      .load_i      (load[g]),
      .load_char_i (s_axis_tdata),
      .wave_i      (wave[g]),
      .wave_o      (wave[g+1])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_ovf_q, out_match_q};
  assign m_axis_tlast  = out_end_q;

endmodule

// File: hw/rtl/wgm_checker.sv
// port-level checks of the glob matcher and their bind to the top level
// depends on wgm_pkg and wildcard_glob_matcher_core_defines.svh
`include "wildcard_glob_matcher_core_defines.svh"

module wgm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tlast,
  input logic       s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);
  import wgm_pkg::*;

  logic pat_word;
  assign pat_word = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_PATTERN);

  // a stalled result keeps its word
  `WGM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // closing a pattern starts the row walk, so no word is taken next cycle
  `WGM_ASSERT_NEXT(a_close_busy, clk_i, rst_ni, pat_word && s_axis_tlast, !s_axis_tready)

  // an inner pattern byte is stored at once and the input stays open
  `WGM_ASSERT_NEXT(a_load_open, clk_i, rst_ni, pat_word && !s_axis_tlast, s_axis_tready)

endmodule

bind wildcard_glob_matcher_core wgm_checker u_wgm_checker (.*);

// File: tb/sv/wgm_verdict_checker.sv
// result checker of the glob matcher: tracks the pattern and match row on its own,
// compares every result word with the oldest predicted verdict
// depends on wgm_pkg
module wgm_verdict_checker #(
  parameter int MaxPattern = wgm_pkg::MaxPatternDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  input  logic       in_kind_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_data_i,
  input  logic       out_last_i,
  output int         fail_count_o = 0,
  output int         pending_o = 0
);
  timeunit 1ns;
  timeprecision 1ps;
  import wgm_pkg::*;

  typedef struct packed {
    logic matched;
    logic text_end;
    logic overflow;
  } verdict_t;

  verdict_t verdict_q[$];

  // shadow of the block state
  logic [7:0]        glob_mem [MaxPattern];
  int                glob_len;
  logic              glob_closed;
  logic              glob_ovf;
  logic [MaxPattern:0] base_row;
  logic [MaxPattern:0] live_row;

  task automatic absorb_word(input req_type_e kind, input logic [7:0] ch, input logic fin);
    logic diag;
    logic above;
    if (kind == REQ_PATTERN) begin
      if (glob_closed) begin
        glob_len    = 0;
        glob_ovf    = 1'b0;
        glob_closed = 1'b0;
      end
      if (glob_len < MaxPattern) begin
        glob_mem[glob_len] = ch;
        glob_len++;
      end else begin
        glob_ovf = 1'b1;
      end
      if (fin) begin
        glob_closed = 1'b1;
        // prefix i matches the empty text only while it is all stars
        base_row    = '0;
        base_row[0] = 1'b1;
        for (int i = 1; i <= glob_len; i++) begin
          base_row[i] = base_row[i-1] && (glob_mem[i-1] == StarCode);
        end
        live_row = base_row;
        verdict_q.push_back('{matched: live_row[glob_len], text_end: 1'b0,
                              overflow: glob_ovf});
      end
    end else if (glob_closed) begin
      diag        = live_row[0];
      live_row[0] = 1'b0;
      for (int j = 1; j <= glob_len; j++) begin
        above = live_row[j];
        if (glob_mem[j-1] == StarCode) begin
          live_row[j] = live_row[j-1] | above;
        end else if (glob_mem[j-1] == QuestionCode || glob_mem[j-1] == ch) begin
          live_row[j] = diag;
        end else begin
          live_row[j] = 1'b0;
        end
        diag = above;
      end
      verdict_q.push_back('{matched: live_row[glob_len], text_end: fin,
                            overflow: glob_ovf});
      if (fin) begin
        live_row = base_row;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    verdict_t want;
    string    exp_s;
    string    got_s;
    if (!rst_ni) begin
      verdict_q.delete();
      glob_len    = 0;
      glob_closed = 1'b1;
      glob_ovf    = 1'b0;
      base_row    = '0;
      base_row[0] = 1'b1;
      live_row    = base_row;
      foreach (glob_mem[i]) glob_mem[i] = '0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        absorb_word(req_type_e'(in_kind_i), in_char_i, in_last_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result word, got matched=%0b overflow=%0b text_end=%0b",
                   $time, out_data_i[0], out_data_i[1], out_last_i);
          fail_count_o++;
        end else begin
          want = verdict_q.pop_front();
          if (out_data_i[0] !== want.matched || out_data_i[1] !== want.overflow ||
              out_data_i[7:2] !== 6'b0 || out_last_i !== want.text_end) begin
            exp_s = $sformatf("matched=%0b overflow=%0b text_end=%0b pad=00",
                              want.matched, want.overflow, want.text_end);
            got_s = $sformatf("matched=%0b overflow=%0b text_end=%0b pad=%h",
                              out_data_i[0], out_data_i[1], out_last_i, out_data_i[7:2]);
            $display("%0t: result mismatch, expected %s, got %s", $time, exp_s, got_s);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = verdict_q.size();
  end

endmodule

// File: tb/sv/wildcard_glob_matcher_core_tb.sv
// testbench top of the glob matcher: clock, reset, word stimulus and verdict
// depends on wgm_pkg, wildcard_glob_matcher_core and wgm_verdict_checker
module wildcard_glob_matcher_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wgm_pkg::*;

  localparam int MaxPattern  = MaxPatternDef;
  localparam int WordBudget  = 900;
  // last stretch of the run goes without any idling
  localparam int CalmTail    = 100;
  // one wavefront walk plus some slack
  localparam int DrainCycles = MaxPattern + 8;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] char_code
  logic       s_axis_tlast  = 1'b0;   // last
  logic       s_axis_tuser  = REQ_PATTERN;  // [0] req_type
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [0] matched, [1] overflow, [7:2] zero
  logic       m_axis_tlast;           // text_end

  int fails;
  int pending;

  // idling odds on each side: one chance in N per word or cycle, 0 means never
  int feed_odds  = 0;
  int stall_odds = 0;

  // words that reach the block's logic (ignored text words are not counted)
  int words_sent = 0;
  bit pattern_open = 1'b0;

  always #2 clk_i = ~clk_i;

  wildcard_glob_matcher_core #(
    .MaxPattern(MaxPattern)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  wgm_verdict_checker #(
    .MaxPattern(MaxPattern)
  ) u_verdict_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_char_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .in_kind_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_last_i  (m_axis_tlast),
    .fail_count_o(fails),
    .pending_o   (pending)
  );

  // one word into the block, with an optional idle burst ahead of it
  task automatic push_word(input req_type_e kind, input logic [7:0] ch, input logic fin);
    int gap;
    @(negedge clk_i);
    if (feed_odds != 0 && $urandom_range(1, feed_odds) == 1) begin
      gap = $urandom_range(1, 17);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    // track the open pattern so that dropped text words stay out of the count
    if (kind == REQ_PATTERN) begin
      pattern_open = !fin;
      words_sent++;
    end else if (!pattern_open) begin
      words_sent++;
    end
  endtask

  // a pattern or a text; stray text words get mixed into open patterns now and then
  task automatic send_run(input req_type_e kind, input logic [7:0] run_q[$],
                          input logic close);
    for (int i = 0; i < run_q.size(); i++) begin
      if (kind == REQ_PATTERN && i > 0 && $urandom_range(0, 15) == 0) begin
        push_word(REQ_TEXT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      push_word(kind, run_q[i], close && (i == run_q.size() - 1));
    end
  endtask

  // result side: random stall bursts
  initial begin : result_sink
    int gap;
    forever begin
      @(negedge clk_i);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        gap = $urandom_range(1, 17);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] glob_q[$];
    logic [7:0] text_q[$];
    int glob_len;
    int texts;
    int seq;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // text with no pattern loaded: the empty pattern never matches a byte
    push_word(REQ_TEXT, 8'h61, 1'b0);
    push_word(REQ_TEXT, 8'hFF, 1'b1);
    // lone star matches the empty text, and a star byte in the text too
    push_word(REQ_PATTERN, StarCode, 1'b1);
    push_word(REQ_TEXT, StarCode, 1'b1);
    // extreme literals around a question mark
    push_word(REQ_PATTERN, 8'h00, 1'b0);
    push_word(REQ_PATTERN, QuestionCode, 1'b0);
    push_word(REQ_PATTERN, 8'hFF, 1'b1);
    push_word(REQ_TEXT, 8'h00, 1'b0);
    push_word(REQ_TEXT, StarCode, 1'b0);
    push_word(REQ_TEXT, 8'hFF, 1'b1);
    // text word while the pattern is still open gets dropped
    push_word(REQ_PATTERN, 8'h78, 1'b0);
    push_word(REQ_TEXT, 8'h78, 1'b1);
    push_word(REQ_PATTERN, StarCode, 1'b1);
    push_word(REQ_TEXT, 8'h78, 1'b1);
    // question mark against one byte
    push_word(REQ_PATTERN, QuestionCode, 1'b1);
    push_word(REQ_TEXT, 8'h71, 1'b1);

    seq = 0;
    while (words_sent < WordBudget) begin
      if (words_sent >= WordBudget - CalmTail) begin
        feed_odds  = 0;
        stall_odds = 0;
      end else if (seq % 4 == 0) begin
        case ($urandom_range(0, 2))
          0:       feed_odds = 0;
          1:       feed_odds = 3;
          default: feed_odds = 12;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_odds = 0;
          1:       stall_odds = 3;
          default: stall_odds = 12;
        endcase
      end

      // pattern: mostly short, first one overflows, second fills the store exactly
      glob_q.delete();
      if (seq == 0) begin
        glob_len = MaxPattern + 8;
      end else if (seq == 1) begin
        glob_len = MaxPattern;
      end else if ($urandom_range(0, 15) == 0) begin
        glob_len = $urandom_range(MaxPattern - 7, MaxPattern + 8);
      end else begin
        glob_len = $urandom_range(1, 8);
      end
      repeat (glob_len) begin
        case ($urandom_range(0, 9))
          0, 1, 2: glob_q.push_back(StarCode);
          3, 4:    glob_q.push_back(QuestionCode);
          5, 6, 7: glob_q.push_back(8'h61 + 8'($urandom_range(0, 2)));
          default: glob_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      send_run(REQ_PATTERN, glob_q, 1'b1);

      // texts: mostly expanded from the pattern, some damaged, some pure noise
      texts = $urandom_range(1, 4);
      repeat (texts) begin
        text_q.delete();
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          foreach (glob_q[pos]) begin
            if (glob_q[pos] == StarCode) begin
              repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 3) == 0) begin
                  text_q.push_back(8'($urandom_range(0, 255)));
                end else begin
                  text_q.push_back(8'h61 + 8'($urandom_range(0, 2)));
                end
              end
            end else if (glob_q[pos] == QuestionCode) begin
              text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
              text_q.push_back(glob_q[pos]);
            end
          end
          if ($urandom_range(0, 3) == 0 && text_q.size() != 0) begin
            text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
          end
        end
        if (text_q.size() == 0) begin
          text_q.push_back(8'h61);
        end
        // now and then the text is left open and runs into the next one
        send_run(REQ_TEXT, text_q, $urandom_range(0, 9) != 0);
      end
      seq++;
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/wgm_pkg.sv
hw/rtl/wgm_cell.sv
hw/rtl/wildcard_glob_matcher_core.sv
hw/rtl/wgm_checker.sv
tb/sv/wgm_verdict_checker.sv
tb/sv/wildcard_glob_matcher_core_tb.sv
